// ===== design/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Holds the word formats of both channels and the cell interface structs.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEFAULT_DEPTH = 256;
  localparam int ENTRY_IDX_W   = 8;
  localparam int ENTRY_CNT_W   = 9;
  localparam int KEY_PART_W    = 32;

  // The directory number sits in the upper half, so an unsigned compare of the
  // whole key orders by directory first and by file second.
  typedef struct packed {
    logic [KEY_PART_W-1:0] dir_number;
    logic [KEY_PART_W-1:0] file_number;
  } key_t;

  typedef struct packed {
    logic [KEY_PART_W-1:0] dir_number;
    logic [KEY_PART_W-1:0] file_number;
    logic                  create_if_absent;
  } in_word_t;

  typedef struct packed {
    logic                   hit;
    logic                   inserted;
    logic                   full_res;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [ENTRY_CNT_W-1:0] entries_in_use;
  } out_word_t;

  // Status that a cell reports about the broadcast key.
  typedef struct packed {
    logic match;
    logic after;
  } cell_stat_t;

  // Update command for one cell.
  typedef struct packed {
    logic shift_in;
    logic load_new;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } skt_state_t;

endpackage

// ===== design/sorted_key_table_find_or_insert_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_find_or_insert_core: sorted key table, find or insert
// Sequence: an accepted input word is captured in req_r, then the lookup step
//   searches and updates the table and loads the result register, waiting while
//   the result channel stalls. A new input word is accepted only after that
//   lookup step.
// Reset: rst_n (synchronous, active low) empties the table and the output.
// ----------------------------------------------------------------------------
module sorted_key_table_find_or_insert_core
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // Staging widths so the reported fields can be cut to their port widths
  // whether the internal values are narrower or wider.
  localparam int XIW = (IW > ENTRY_IDX_W) ? IW : ENTRY_IDX_W;
  localparam int XCW = (CW > ENTRY_CNT_W) ? CW : ENTRY_CNT_W;

  // The table is a row of cells. Cell i holds entry i, and the entries below
  // the fill count are kept in ascending key order. A request is captured in
  // req_r and its key broadcast to every cell. Each cell reports whether its
  // key equals the broadcast key and whether it sorts after it. Because the
  // table is sorted, the "after" flags form a run at the top of the valid
  // region, so the insertion point is the cell where that run begins, or the
  // first free cell when no valid entry sorts after the key.

  skt_state_t state_r;
  skt_state_t state_nxt;

  in_word_t        req_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            out_valid_r;
  out_word_t       out_word_r;
  out_word_t       out_word_nxt;

  key_t             key_bcast;
  key_t             cell_key   [TABLE_DEPTH];
  cell_stat_t       cell_stat  [TABLE_DEPTH];
  cell_ctl_t        cell_ctl   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] after_vec;
  logic [TABLE_DEPTH-1:0] bound_vec;

  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic          bound_any;
  logic [IW-1:0] bound_idx;
  logic          table_full;
  logic          do_lookup;
  logic          do_insert;
  logic [IW-1:0] ins_pos;
  logic [IW-1:0] idx_sel;
  logic [XIW-1:0] idx_ext;
  logic [XCW-1:0] cnt_ext;
  logic           accept_in;

  assign key_bcast.dir_number  = req_r.dir_number;
  assign key_bcast.file_number = req_r.file_number;

  // The lookup step runs only when the output register can take its result.
  assign do_lookup = (state_r == ST_LOOKUP) && (!out_valid_r || out_ready);
  assign accept_in = in_valid && in_ready;

  assign table_full = (count_r == CW'(TABLE_DEPTH));
  assign do_insert  = do_lookup && !hit_any && req_r.create_if_absent && !table_full;

  // When no valid entry sorts after the key it goes into the first free cell.
  // That case only arises below a full table, so the count fits the index.
  assign ins_pos = bound_any ? bound_idx : count_r[IW-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic entry_valid;
      key_t prev_key;

      assign entry_valid = (CW'(gi) < count_r);
      assign match_vec[gi] = cell_stat[gi].match;
      assign after_vec[gi] = cell_stat[gi].after;

      if (gi == 0) begin : g_first
        assign bound_vec[gi]        = after_vec[gi];
        assign prev_key             = key_bcast;
        assign cell_ctl[gi].shift_in = 1'b0;
      end else begin : g_rest
        assign bound_vec[gi]        = after_vec[gi] && !after_vec[gi-1];
        assign prev_key             = cell_key[gi-1];
        // Every entry above the insertion point, and the first free cell,
        // takes the key of its lower neighbor.
        assign cell_ctl[gi].shift_in = do_insert && after_vec[gi-1];
      end

      assign cell_ctl[gi].load_new = do_insert &&
        (bound_vec[gi] || (!bound_any && (CW'(gi) == count_r)));

      skt_cell u_cell (
        .clk         (clk),
        .key_bcast   (key_bcast),
        .entry_valid (entry_valid),
        .prev_key    (prev_key),
        .ctl         (cell_ctl[gi]),
        .key_o       (cell_key[gi]),
        .stat_o      (cell_stat[gi])
      );
    end
  endgenerate

  // Keys are unique, so at most one cell matches.
  skt_encoder #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IW)
  ) u_hit_enc (
    .sel (match_vec),
    .idx (hit_idx),
    .any (hit_any)
  );

  // The start of the "after" run is a single cell as well.
  skt_encoder #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IW)
  ) u_bound_enc (
    .sel (bound_vec),
    .idx (bound_idx),
    .any (bound_any)
  );

  assign count_nxt = count_r + CW'(do_insert);

  always_comb begin
    if (hit_any) begin
      idx_sel = hit_idx;
    end else if (do_insert) begin
      idx_sel = ins_pos;
    end else begin
      idx_sel = '0;
    end
  end

  assign idx_ext = XIW'(idx_sel);
  assign cnt_ext = XCW'(count_nxt);

  always_comb begin
    out_word_nxt.hit            = hit_any;
    out_word_nxt.inserted       = do_insert;
    out_word_nxt.full_res       = !hit_any && req_r.create_if_absent && table_full;
    out_word_nxt.entry_index    = idx_ext[ENTRY_IDX_W-1:0];
    out_word_nxt.entries_in_use = cnt_ext[ENTRY_CNT_W-1:0];
  end

  // Control sequence: capture a request, then look it up and update.
  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = accept_in ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: begin
        state_nxt = do_lookup ? ST_IDLE : ST_LOOKUP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (do_lookup) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req_r <= in_word;
    end
    if (do_lookup) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== design/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// Compares its key with the broadcast key and takes either its lower
// neighbor's key or the new key when an insertion opens a slot.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
(
  input  logic       clk,
  input  key_t       key_bcast,
  input  logic       entry_valid,
  input  key_t       prev_key,
  input  cell_ctl_t  ctl,
  output key_t       key_o,
  output cell_stat_t stat_o
);

  key_t key_r;
  key_t key_nxt;

  always_comb begin
    stat_o.match = entry_valid && (key_r == key_bcast);
    stat_o.after = entry_valid && (key_r > key_bcast);
  end

  always_comb begin
    priority if (ctl.load_new) begin
      key_nxt = key_bcast;
    end else if (ctl.shift_in) begin
      key_nxt = prev_key;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;

endmodule

// ===== design/skt_encoder.sv =====
// ----------------------------------------------------------------------------
// skt_encoder: one-hot to binary encoder
// Turns a vector with at most one bit set into its position and a flag.
// ----------------------------------------------------------------------------
module skt_encoder
  import skt_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] sel,
  output logic [IDX_W-1:0] idx,
  output logic             any
);

  // With a single bit set, OR-ing the positions gives that position.
  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign any = |sel;

endmodule
